[src/bfm_pkg.sv]
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared constants, register codes and pipeline types of the brush footprint
// membership block.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // largest normalized brush size on either axis
   localparam int MAX_SIZE = 15;

   // tolerance of the round test as a ratio: inside when dist_sum < 201/200 * area (<= in exact mode)
   localparam int EPS_NUM = 201;
   localparam int EPS_DEN = 200;

   // widths of the fields
   localparam int OFFSET_W = 7;
   localparam int SIZE_W   = 4;
   localparam int SQ_W     = 2 * SIZE_W;
   localparam int PROD_W   = 2 * SQ_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int CMP_W    = SUM_W + 8;

   // brush shape codes
   localparam logic SHAPE_SQUARE = 1'b0;
   localparam logic SHAPE_ROUND  = 1'b1;

   // control register indexes
   typedef enum logic [1:0] {
      CSR_BRUSH_SHAPE = 2'd0,
      CSR_EXACT_MODE  = 2'd1,
      CSR_SIZE_X      = 2'd2,
      CSR_SIZE_Y      = 2'd3
   } csr_index_type;

   // per-axis geometry of one offset
   typedef struct packed {
      logic              box_ok;
      logic [SIZE_W-1:0] norm_size;
      logic [SIZE_W-1:0] div_size;
      logic [SIZE_W-1:0] reach;
      logic [SIZE_W-1:0] mag;
   } axis_info_type;

   // fields that ride along the pipeline unchanged
   typedef struct packed {
      logic              box_ok;
      logic              round;
      logic              exact;
      logic [SIZE_W-1:0] reach_x;
      logic [SIZE_W-1:0] reach_y;
      logic [SIZE_W-1:0] larger;
   } meta_type;

   typedef struct packed {
      meta_type          meta;
      logic [SIZE_W-1:0] mag_x;
      logic [SIZE_W-1:0] mag_y;
      logic [SIZE_W-1:0] div_x;
      logic [SIZE_W-1:0] div_y;
   } stage1_type;

   typedef struct packed {
      meta_type        meta;
      logic [SQ_W-1:0] sq_mag_x;
      logic [SQ_W-1:0] sq_mag_y;
      logic [SQ_W-1:0] sq_div_x;
      logic [SQ_W-1:0] sq_div_y;
   } stage2_type;

   typedef struct packed {
      meta_type          meta;
      logic [PROD_W-1:0] term_x;
      logic [PROD_W-1:0] term_y;
      logic [PROD_W-1:0] area;
   } stage3_type;

   typedef struct packed {
      meta_type          meta;
      logic [SUM_W-1:0]  dist_sum;
      logic [PROD_W-1:0] area;
   } stage4_type;

endpackage

[src/bfm_if.sv]
// ----------------------------------------------------------------------------
// bfm request and response channels
// Valid/ready channels carrying one offset query and one membership result.
// ----------------------------------------------------------------------------
interface bfm_req_if;
   logic              valid;
   logic              ready;
   logic signed [6:0] offset_x;
   logic signed [6:0] offset_y;

   modport source (output valid, output offset_x, output offset_y, input ready);
   modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface bfm_rsp_if;
   logic       valid;
   logic       ready;
   logic       inside_res;
   logic [3:0] reach_x;
   logic [3:0] reach_y;
   logic [3:0] larger_size;

   modport source (output valid, output inside_res, output reach_x, output reach_y,
                   output larger_size, input ready);
   modport sink   (input valid, input inside_res, input reach_x, input reach_y,
                   input larger_size, output ready);
endinterface

[src/brush_footprint_membership.sv]
// ----------------------------------------------------------------------------
// brush_footprint_membership
// Tests whether a cell offset lies inside a square or round brush footprint.
// ----------------------------------------------------------------------------
// A query transferred on req_if gives its result on rsp_if, and a new query
// can be transferred in every cycle: the path is a five stage pipeline
// (bounds, squares, cross products, sum, tolerance compare) that only stops
// when the result register is full and rsp_if is not ready. Control registers
// are written through csr_write_en/csr_index/csr_write_data and take effect
// for the next query; write them only while no query is in flight.
module brush_footprint_membership (
   input  logic                   clock,
   input  logic                   reset,
   bfm_req_if.sink                req_if,
   bfm_rsp_if.source              rsp_if,
   input  logic                   csr_write_en,
   input  bfm_pkg::csr_index_type csr_index,
   input  logic [3:0]             csr_write_data
);
   import bfm_pkg::*;

   // control registers
   logic              shape_ff;
   logic              exact_ff;
   logic [SIZE_W-1:0] size_x_ff;
   logic [SIZE_W-1:0] size_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= SHAPE_SQUARE;
         exact_ff  <= 1'b0;
         size_x_ff <= '0;
         size_y_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BRUSH_SHAPE: shape_ff  <= csr_write_data[0];
            CSR_EXACT_MODE:  exact_ff  <= csr_write_data[0];
            CSR_SIZE_X:      size_x_ff <= csr_write_data[SIZE_W-1:0];
            CSR_SIZE_Y:      size_y_ff <= csr_write_data[SIZE_W-1:0];
         endcase
      end
   end

   // pipeline advances whenever the result register can take a new value
   logic advance;
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff    <= req_if.valid;
         valid2_ff    <= valid1_ff;
         valid3_ff    <= valid2_ff;
         valid4_ff    <= valid3_ff;
         rsp_valid_ff <= valid4_ff;
      end
   end

   // stage 1: per-axis bounds and coordinates
   axis_info_type info_x, info_y;
   stage1_type    st1_in, st1_ff;

   bfm_axis u_axis_x (
      .size_reg (size_x_ff),
      .exact    (exact_ff),
      .offset   (req_if.offset_x),
      .info     (info_x)
   );

   bfm_axis u_axis_y (
      .size_reg (size_y_ff),
      .exact    (exact_ff),
      .offset   (req_if.offset_y),
      .info     (info_y)
   );

   always_comb begin
      st1_in.meta.box_ok  = info_x.box_ok && info_y.box_ok;
      st1_in.meta.round   = (shape_ff == SHAPE_ROUND);
      st1_in.meta.exact   = exact_ff;
      st1_in.meta.reach_x = info_x.reach;
      st1_in.meta.reach_y = info_y.reach;
      st1_in.meta.larger  = (info_x.norm_size > info_y.norm_size) ?
                            info_x.norm_size : info_y.norm_size;
      st1_in.mag_x        = info_x.mag;
      st1_in.mag_y        = info_y.mag;
      st1_in.div_x        = info_x.div_size;
      st1_in.div_y        = info_y.div_size;
   end

   // stage 2: squares of coordinates and radii
   stage2_type st2_in, st2_ff;

   always_comb begin
      st2_in.meta     = st1_ff.meta;
      st2_in.sq_mag_x = st1_ff.mag_x * st1_ff.mag_x;
      st2_in.sq_mag_y = st1_ff.mag_y * st1_ff.mag_y;
      st2_in.sq_div_x = st1_ff.div_x * st1_ff.div_x;
      st2_in.sq_div_y = st1_ff.div_y * st1_ff.div_y;
   end

   // stage 3: cross products of the ellipse inequality
   stage3_type st3_in, st3_ff;

   always_comb begin
      st3_in.meta   = st2_ff.meta;
      st3_in.term_x = st2_ff.sq_mag_x * st2_ff.sq_div_y;
      st3_in.term_y = st2_ff.sq_mag_y * st2_ff.sq_div_x;
      st3_in.area   = st2_ff.sq_div_x * st2_ff.sq_div_y;
   end

   // stage 4: sum of the distance terms
   stage4_type st4_in, st4_ff;

   always_comb begin
      st4_in.meta     = st3_ff.meta;
      st4_in.dist_sum = {1'b0, st3_ff.term_x} + {1'b0, st3_ff.term_y};
      st4_in.area     = st3_ff.area;
   end

   // stage 5: scaled compare with tolerance, result register
   logic [CMP_W-1:0]  lhs, rhs;
   logic              ellipse_ok;
   logic              inside_in, inside_ff;
   logic [SIZE_W-1:0] reach_x_ff, reach_y_ff, larger_ff;

   always_comb begin
      lhs        = CMP_W'(st4_ff.dist_sum) * CMP_W'(EPS_DEN);
      rhs        = CMP_W'(st4_ff.area) * CMP_W'(EPS_NUM);
      ellipse_ok = st4_ff.meta.exact ? (lhs <= rhs) : (lhs < rhs);
      inside_in  = st4_ff.meta.box_ok && (!st4_ff.meta.round || ellipse_ok);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff     <= st1_in;
         st2_ff     <= st2_in;
         st3_ff     <= st3_in;
         st4_ff     <= st4_in;
         inside_ff  <= inside_in;
         reach_x_ff <= st4_ff.meta.reach_x;
         reach_y_ff <= st4_ff.meta.reach_y;
         larger_ff  <= st4_ff.meta.larger;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.inside_res  = inside_ff;
   assign rsp_if.reach_x     = reach_x_ff;
   assign rsp_if.reach_y     = reach_y_ff;
   assign rsp_if.larger_size = larger_ff;

endmodule

[src/bfm_axis.sv]
// ----------------------------------------------------------------------------
// bfm_axis
// One axis of the footprint: size normalization, span bounds, box test and
// the centred coordinate magnitude used by the round test.
// ----------------------------------------------------------------------------
module bfm_axis (
   input  logic [bfm_pkg::SIZE_W-1:0]          size_reg,
   input  logic                                exact,
   input  logic signed [bfm_pkg::OFFSET_W-1:0] offset,
   output bfm_pkg::axis_info_type              info
);
   import bfm_pkg::*;

   localparam logic [OFFSET_W-1:0] MAX_SIZE_W = OFFSET_W'(MAX_SIZE);

   logic [SIZE_W-1:0]          size_n;
   logic signed [OFFSET_W-1:0] size_s;
   logic signed [OFFSET_W-1:0] half_s;
   logic signed [OFFSET_W-1:0] lo;
   logic signed [OFFSET_W-1:0] hi;
   logic signed [OFFSET_W:0]   center2;
   logic signed [OFFSET_W:0]   coord;
   logic [OFFSET_W:0]          coord_abs;

   always_comb begin
      // clamp the size into its legal range
      size_n = size_reg;
      if (exact && size_reg == '0) begin
         size_n = SIZE_W'(1);
      end
      if ({{(OFFSET_W-SIZE_W){1'b0}}, size_n} > MAX_SIZE_W) begin
         size_n = SIZE_W'(MAX_SIZE);
      end
      size_s = signed'({{(OFFSET_W-SIZE_W){1'b0}}, size_n});
      half_s = signed'({{(OFFSET_W-SIZE_W+1){1'b0}}, size_n[SIZE_W-1:1]});

      // span bounds and reach
      priority if (!exact) begin
         lo         = -size_s;
         hi         = size_s;
         info.reach = size_n;
      end else if (size_n[0]) begin
         lo         = -half_s;
         hi         = half_s;
         info.reach = size_n >> 1;
      end else begin
         lo         = OFFSET_W'(1) - size_s;
         hi         = '0;
         info.reach = size_n - SIZE_W'(1);
      end

      info.box_ok    = (offset >= lo) && (offset <= hi);
      info.norm_size = size_n;
      info.div_size  = (size_n == '0) ? SIZE_W'(1) : size_n;

      // doubled coordinate about the span centre in exact mode
      center2 = {lo[OFFSET_W-1], lo} + {hi[OFFSET_W-1], hi};
      if (exact) begin
         coord = {offset, 1'b0} - center2;
      end else begin
         coord = {offset[OFFSET_W-1], offset};
      end
      coord_abs = coord[OFFSET_W] ? unsigned'(-coord) : unsigned'(coord);
      info.mag  = coord_abs[SIZE_W-1:0];
   end

endmodule

[src/bfm_checker.sv]
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks of the brush footprint membership block, bound to the
// top level.
// ----------------------------------------------------------------------------
module bfm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       inside_res,
   input logic [3:0] reach_x,
   input logic [3:0] reach_y,
   input logic [3:0] larger_size
);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(inside_res) &&
      $stable(reach_x) && $stable(reach_y) && $stable(larger_size))
      else $error("stalled result changed");

   // no result survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register never blocks a new query
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // the reach on either axis never exceeds the larger size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (reach_x <= larger_size) && (reach_y <= larger_size))
      else $error("reach larger than brush size");

endmodule

bind brush_footprint_membership bfm_checker u_bfm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .inside_res  (rsp_if.inside_res),
   .reach_x     (rsp_if.reach_x),
   .reach_y     (rsp_if.reach_y),
   .larger_size (rsp_if.larger_size)
);
